// ===== rtl/nss_pkg.sv =====
// Shared constants, field layout and types for the nearest segment search.
package nss_pkg;

  // Coordinate and distance widths (signed Q8.16 in, unsigned Q20.32 out)
  localparam int COORD_BITS = 24;
  localparam int ENTRY_BITS = 3 * COORD_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int DIST_BITS  = 52;

  // Field widths
  localparam int IDX_BITS   = 6;
  localparam int COUNT_BITS = 7;
  localparam int SPAN_BITS  = 6;

  // Stream payload layout
  localparam int IN_FIELD_BITS  = IDX_BITS + ENTRY_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_PAD_BITS    = IN_DATA_BITS - IN_FIELD_BITS;
  localparam int OUT_FIELD_BITS = 3 * IDX_BITS + DIST_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

  // Configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = COUNT_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SEGMENT_COUNT = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEIGHBOR_SPAN = 1'b1;

  // Opcodes carried on in_tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Control travelling with each entry down the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

// ===== rtl/nss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nss_dist.sv =====
// Squared-distance pipeline: difference, square, sum, one register each.
module nss_dist #(
  parameter int AW = 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nss_pkg::tag_t                    tag_in,
  input  logic [AW-1:0]                    idx_in,
  input  logic [nss_pkg::ENTRY_BITS-1:0]   rd_data,
  input  logic [nss_pkg::ENTRY_BITS-1:0]   q_point,
  output nss_pkg::tag_t                    tag_out,
  output logic [AW-1:0]                    idx_out,
  output logic [nss_pkg::DIST_BITS-1:0]    dist_out
);
  import nss_pkg::*;

  tag_t                tag1_r, tag2_r, tag3_r, tag4_r;
  logic [AW-1:0]       idx1_r, idx2_r, idx3_r, idx4_r;
  logic [MAG_BITS-1:0] mag_nxt [3];
  logic [MAG_BITS-1:0] mag2_r  [3];
  logic [SQ_BITS-1:0]  sq3_r   [3];
  logic [DIST_BITS-1:0] sum4_r;

  // |centre - query| per axis; magnitude always fits COORD_BITS
  always_comb begin
    logic [COORD_BITS-1:0] c, q;
    logic [DIFF_BITS-1:0]  d;
    for (int k = 0; k < 3; k++) begin
      c = rd_data[k*COORD_BITS +: COORD_BITS];
      q = q_point[k*COORD_BITS +: COORD_BITS];
      d = {c[COORD_BITS-1], c} - {q[COORD_BITS-1], q};
      mag_nxt[k] = d[DIFF_BITS-1] ? MAG_BITS'(-d) : MAG_BITS'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
    idx1_r <= idx_in;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    for (int k = 0; k < 3; k++) begin
      mag2_r[k] <= mag_nxt[k];
      sq3_r[k]  <= SQ_BITS'(mag2_r[k]) * SQ_BITS'(mag2_r[k]);
    end
    // three squares below 2^48 never reach the 52-bit ceiling
    sum4_r <= DIST_BITS'(sq3_r[0]) + DIST_BITS'(sq3_r[1]) + DIST_BITS'(sq3_r[2]);
  end

  assign tag_out  = tag4_r;
  assign idx_out  = idx4_r;
  assign dist_out = sum4_r;

endmodule

// ===== rtl/nearest_segment_search.sv =====
// Nearest segment search: top level with sequencer, best tracker and output register.
//
// Holds up to MAX_SEGMENTS 3-D centres (signed Q8.16) in a single-port-read
// RAM. A load transaction (tuser = 0) writes one centre; slots at or beyond
// MAX_SEGMENTS are dropped. A query transaction (tuser = 1) streams the first
// segment_count centres (saturated to MAX_SEGMENTS) out of the RAM at one
// entry per cycle into a four-stage squared-distance pipeline and keeps the
// strictly smallest distance, so ties resolve to the lowest index. The RAM
// read port, one entry a cycle, paces the scan; an empty table skips it.
// in_tready is low while a query is in flight; the result sits in an output
// register, so the next transaction is taken while it waits on out_tready.
// The result carries the index, the Q20.32 distance and a window of index
// +/- neighbor_span clamped to [0, count-1]; with an empty table found is 0
// and every other field reads 0. Registers are written through cfg_* and
// should only change while the block is idle. Entries must be loaded before
// a query reaches them; the RAM has no reset.
module nearest_segment_search #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: entry_index[5:0], coord_x[29:6], coord_y[53:30], coord_z[77:54], zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [nss_pkg::IN_DATA_BITS-1:0]     in_tdata,
  input  logic                                 in_tuser,    // opcode
  // out_tdata: closest_index[5:0], best_distance_sq[57:6], window_low[63:58],
  //            window_high[69:64], zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [nss_pkg::OUT_DATA_BITS-1:0]    out_tdata,
  output logic                                 out_tuser,   // found
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [nss_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import nss_pkg::*;

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int WW = ((CW > SPAN_BITS) ? CW : SPAN_BITS) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_FINISH} state_t;

  state_t                state_r, state_nxt;
  logic [COUNT_BITS-1:0] seg_count_r;
  logic [SPAN_BITS-1:0]  span_r;
  logic [CW-1:0]         cnt_r, cnt_sat;
  logic [ENTRY_BITS-1:0] q_point_r;
  logic [AW-1:0]         rd_addr_r, last_addr;
  logic [AW-1:0]         best_idx_r;
  logic [DIST_BITS-1:0]  best_sq_r;
  logic                  out_valid_r, out_found_r;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic [IDX_BITS-1:0]   in_entry;
  logic                  in_fire, query_fire, load_wr;
  logic [ENTRY_BITS-1:0] rd_data;
  tag_t                  tag0, tag4;
  logic [AW-1:0]         idx4;
  logic [DIST_BITS-1:0]  dist4;
  logic                  better, found, out_free;
  logic [WW-1:0]         win_lo, win_hi;

  assign in_entry   = in_tdata[IDX_BITS-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign query_fire = in_fire && (in_tuser == OP_QUERY);
  assign load_wr    = in_fire && (in_tuser == OP_LOAD) && (int'(in_entry) < MAX_SEGMENTS);
  assign cfg_ready  = 1'b1;

  // counts above the table depth search the whole table
  always_comb begin
    if (int'(seg_count_r) > MAX_SEGMENTS) begin
      cnt_sat = CW'(MAX_SEGMENTS);
    end else begin
      cnt_sat = CW'(seg_count_r);
    end
  end

  assign last_addr  = AW'(cnt_r - CW'(1));
  assign tag0.valid = (state_r == S_SCAN);
  assign tag0.last  = (rd_addr_r == last_addr);

  nss_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_SEGMENTS)
  ) u_centres (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (AW'(in_entry)),
    .wr_data (in_tdata[IDX_BITS +: ENTRY_BITS]),
    .rd_en   (tag0.valid),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  nss_dist #(
    .AW (AW)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (tag0),
    .idx_in   (rd_addr_r),
    .rd_data  (rd_data),
    .q_point  (q_point_r),
    .tag_out  (tag4),
    .idx_out  (idx4),
    .dist_out (dist4)
  );

  // first entry always seeds the best; later ones must be strictly closer
  assign better   = tag4.valid && ((idx4 == '0) || (dist4 < best_sq_r));
  assign found    = (cnt_r != '0);
  assign out_free = !out_valid_r || out_tready;

  // window clamped to [0, count-1]
  always_comb begin
    logic [WW-1:0] bw, sw, cw;
    bw = WW'(best_idx_r);
    sw = WW'(span_r);
    cw = WW'(cnt_r);
    win_lo = (bw >= sw) ? (bw - sw) : '0;
    win_hi = bw + sw;
    if (win_hi >= cw) begin
      win_hi = cw - WW'(1);
    end
  end

  always_comb begin
    if (found) begin
      out_data_nxt = {{OUT_PAD_BITS{1'b0}}, IDX_BITS'(win_hi), IDX_BITS'(win_lo),
                      best_sq_r, IDX_BITS'(best_idx_r)};
    end else begin
      out_data_nxt = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (query_fire) begin
          state_nxt = (cnt_sat == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (tag0.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (tag4.valid && tag4.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_count_r <= '0;
      span_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SEGMENT_COUNT: seg_count_r <= cfg_data[COUNT_BITS-1:0];
          REG_NEIGHBOR_SPAN: span_r      <= cfg_data[SPAN_BITS-1:0];
        endcase
      end

      if (query_fire) begin
        cnt_r      <= cnt_sat;
        q_point_r  <= in_tdata[IDX_BITS +: ENTRY_BITS];
        rd_addr_r  <= '0;
        best_idx_r <= '0;
        best_sq_r  <= '0;
      end

      if (state_r == S_SCAN) begin
        rd_addr_r <= rd_addr_r + AW'(1);
      end

      if (better) begin
        best_idx_r <= idx4;
        best_sq_r  <= dist4;
      end

      // a fresh result refills the register in the cycle the old one leaves
      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_data_nxt;
        out_found_r <= found;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

// ===== rtl/nss_checker.sv =====
// Port-level checks for the nearest segment search, bound to the top level.
module nss_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [nss_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input logic                               out_tuser
);
  import nss_pkg::*;

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // an empty-table result carries zeros only
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero fields");

  // a query keeps the input side closed for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> !in_tready)
    else $error("input taken right after a query");

endmodule

bind nearest_segment_search nss_checker u_nss_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the nearest segment search block.
module tb_top;
  import nss_pkg::*;

  localparam int SLOTS        = 64;
  localparam int ITEM_TARGET  = 1650;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_GAP      = 11;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int SENDER       = 0;
  localparam int RECEIVER     = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct {
    logic                 found;
    logic [IDX_BITS-1:0]  index;
    logic [DIST_BITS-1:0] dist_sq;
    logic [IDX_BITS-1:0]  low;
    logic [IDX_BITS-1:0]  high;
  } nearest_result_t;

  // Shadow of the centre table and registers; works out each query's answer
  // when the transaction is accepted and queues it for the output side.
  class nearest_scoreboard;
    coord_t                centre_x[SLOTS];
    coord_t                centre_y[SLOTS];
    coord_t                centre_z[SLOTS];
    logic [COUNT_BITS-1:0] seg_count;
    logic [SPAN_BITS-1:0]  span;
    nearest_result_t       awaited_q[$];
    int                    errors;

    function new();
      seg_count = '0;
      span      = '0;
      errors    = 0;
      foreach (centre_x[i]) begin
        centre_x[i] = '0;
        centre_y[i] = '0;
        centre_z[i] = '0;
      end
    endfunction

    static function longint sq_diff(coord_t a, coord_t b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_SEGMENT_COUNT) begin
        seg_count = data[COUNT_BITS-1:0];
      end else if (idx == REG_NEIGHBOR_SPAN) begin
        span = data[SPAN_BITS-1:0];
      end
    endfunction

    function void note_input(logic op, logic [IDX_BITS-1:0] slot, coord_t px, coord_t py,
                             coord_t pz);
      nearest_result_t r;
      int              n;
      int              best;
      int              lo;
      int              hi;
      longint          best_sq;
      longint          s;
      if (op == OP_LOAD) begin
        centre_x[slot] = px;
        centre_y[slot] = py;
        centre_z[slot] = pz;
        return;
      end
      // counts above the table depth are saturated for search and clamp
      n = (seg_count > SLOTS) ? SLOTS : int'(seg_count);
      r = '{default: '0};
      if (n != 0) begin
        best    = 0;
        best_sq = 0;
        // strict less-than keeps the lowest index on a tie; three squares of
        // 25-bit differences stay far below the 52-bit ceiling
        for (int i = 0; i < n; i++) begin
          s = sq_diff(centre_x[i], px) + sq_diff(centre_y[i], py) + sq_diff(centre_z[i], pz);
          if (i == 0 || s < best_sq) begin
            best_sq = s;
            best    = i;
          end
        end
        lo = (best >= int'(span)) ? best - int'(span) : 0;
        hi = best + int'(span);
        if (hi >= n) begin
          hi = n - 1;
        end
        r.found   = 1'b1;
        r.index   = best[IDX_BITS-1:0];
        r.dist_sq = best_sq[DIST_BITS-1:0];
        r.low     = lo[IDX_BITS-1:0];
        r.high    = hi[IDX_BITS-1:0];
      end
      awaited_q.insert(awaited_q.size(), r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(nearest_result_t got);
      nearest_result_t want;
      if (awaited_q.size() == 0) begin
        $error("result transaction with no query outstanding (index %0d)", got.index);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      compare_field("found", 64'(want.found), 64'(got.found));
      compare_field("closest_index", 64'(want.index), 64'(got.index));
      compare_field("best_distance_sq", 64'(want.dist_sq), 64'(got.dist_sq));
      compare_field("window_low", 64'(want.low), 64'(got.low));
      compare_field("window_high", 64'(want.high), 64'(got.high));
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_BITS-1:0]   in_tdata;
  logic                      in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic                      out_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  nearest_scoreboard sb = new();

  int  items_sent;
  bit  loaded[SLOTS];       // slots written since reset; queries never reach others
  bit  pressure_on;         // sender offers back to back
  bit  hold_req;            // asks the sink for one long hold-off
  int  burst_left[2];
  bit  burst_busy[2];

  nearest_segment_search #(.MAX_SEGMENTS(SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // entry_index, coord_x, coord_y, coord_z, pad
    .in_tuser   (in_tuser),     // opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // closest_index, best_distance_sq, window_low, window_high, pad
    .out_tuser  (out_tuser),    // found
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // Runs of busy and quiet stretches, drawn per side; quiet means no gaps.
  function automatic int draw_gap(int side);
    if (burst_left[side] == 0) begin
      burst_left[side] = $urandom_range(1, 40);
      burst_busy[side] = ($urandom_range(0, 3) != 0);
    end
    burst_left[side]--;
    return burst_busy[side] ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0: return C_MAX;
      1: return C_MIN;
      2: return coord_t'(int'($urandom_range(0, 4)) - 2);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // A point a few LSBs from a centre, kept inside the coordinate range.
  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 64)) - 32;
    if (v > int'(C_MAX)) begin
      v = int'(C_MAX);
    end else if (v < int'(C_MIN)) begin
      v = int'(C_MIN);
    end
    return coord_t'(v);
  endfunction

  // Monitors: every accepted transaction is seen here, at the edge it happens.
  always @(posedge clk) begin
    nearest_result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tuser, in_tdata[IDX_BITS-1:0],
                      in_tdata[IDX_BITS +: COORD_BITS],
                      in_tdata[IDX_BITS+COORD_BITS +: COORD_BITS],
                      in_tdata[IDX_BITS+2*COORD_BITS +: COORD_BITS]);
      end
      if (out_tvalid && out_tready) begin
        got.found   = out_tuser;
        got.index   = out_tdata[IDX_BITS-1:0];
        got.dist_sq = out_tdata[IDX_BITS +: DIST_BITS];
        got.low     = out_tdata[IDX_BITS+DIST_BITS +: IDX_BITS];
        got.high    = out_tdata[2*IDX_BITS+DIST_BITS +: IDX_BITS];
        sb.check_result(got);
      end
    end
  end

  task automatic send_item(logic op, logic [IDX_BITS-1:0] slot, coord_t x, coord_t y,
                           coord_t z);
    int gap;
    gap = pressure_on ? 0 : draw_gap(SENDER);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= {{IN_PAD_BITS{1'b0}}, z, y, x, slot};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_slot(logic [IDX_BITS-1:0] slot, coord_t x, coord_t y, coord_t z);
    send_item(OP_LOAD, slot, x, y, z);
    loaded[slot] = 1'b1;
  endtask

  // Idle point: all answers back, then room for a trailing load or search.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers in one burst; the span's spare top bit is random junk.
  task automatic write_regs(logic [COUNT_BITS-1:0] count, logic [SPAN_BITS-1:0] span_val);
    logic junk;
    junk = 1'($urandom_range(0, 1));
    cfg_index <= REG_SEGMENT_COUNT;
    cfg_data  <= count;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_NEIGHBOR_SPAN;
    cfg_data  <= {junk, span_val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result sink: random stalls, and one long hold-off on request.
  initial begin : result_sink
    int gap;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap      = hold_req ? HOLD_CYCLES : draw_gap(RECEIVER);
      hold_req = 1'b0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [COUNT_BITS-1:0] count;
    logic [SPAN_BITS-1:0]  span_val;
    logic [IDX_BITS-1:0]   slot;
    int                    eff;
    int                    n;
    int                    src;
    int                    kind;
    coord_t                x;
    coord_t                y;
    coord_t                z;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_LOAD;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SEGMENT_COUNT;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table straight out of reset: found low, everything else zero.
    send_item(OP_QUERY, '1, C_MAX, C_MAX, C_MAX);
    send_item(OP_QUERY, '0, C_MIN, C_MIN, C_MIN);

    // Corner centres; slot 3 duplicates slot 0 to force a tie.
    load_slot(IDX_BITS'(0), C_MAX, C_MAX, C_MAX);
    load_slot(IDX_BITS'(1), C_MIN, C_MIN, C_MIN);
    load_slot(IDX_BITS'(2), '0, '0, '0);
    load_slot(IDX_BITS'(3), C_MAX, C_MAX, C_MAX);
    load_slot(IDX_BITS'(4), C_MIN, C_MAX, '0);

    // Still empty with the widest span: window must stay at zero.
    settle();
    write_regs(COUNT_BITS'(0), SPAN_BITS'(63));
    send_item(OP_QUERY, '0, '0, '0, '0);

    // Single entry: largest possible distance, then a zero distance.
    settle();
    write_regs(COUNT_BITS'(1), SPAN_BITS'(63));
    send_item(OP_QUERY, '0, C_MIN, C_MIN, C_MIN);
    send_item(OP_QUERY, '1, C_MAX, C_MAX, C_MAX);

    // Five entries, no span: ties resolve low, windows collapse to the hit.
    settle();
    write_regs(COUNT_BITS'(5), SPAN_BITS'(0));
    send_item(OP_QUERY, '0, C_MAX, C_MAX, C_MAX);
    send_item(OP_QUERY, '0, C_MIN, C_MIN, C_MIN);
    send_item(OP_QUERY, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, C_MIN, C_MAX, '0);
    send_item(OP_QUERY, '0, 24'sd1, -24'sd1, 24'sd1);

    // Span of two: a window that just spans [0, count - 1], then one clamped at zero.
    settle();
    write_regs(COUNT_BITS'(5), SPAN_BITS'(2));
    send_item(OP_QUERY, '0, '0, '0, '0);
    send_item(OP_QUERY, '0, C_MIN, C_MIN, C_MIN);

    // Random phases, each with its own register setting.
    for (int ph = 0; items_sent < ITEM_TARGET; ph++) begin
      case ($urandom_range(0, 9))
        0: count = COUNT_BITS'(0);
        1: count = COUNT_BITS'(SLOTS);
        2: count = COUNT_BITS'($urandom_range(SLOTS + 1, (1 << COUNT_BITS) - 1));
        3: count = COUNT_BITS'(1);
        default: count = COUNT_BITS'($urandom_range(2, SLOTS - 1));
      endcase
      case ($urandom_range(0, 5))
        0: span_val = '0;
        1: span_val = '1;
        default: span_val = SPAN_BITS'($urandom_range(0, 20));
      endcase
      settle();
      write_regs(count, span_val);
      eff = (count > SLOTS) ? SLOTS : int'(count);

      // Every slot the search will reach gets a centre first.
      for (int s = 0; s < eff; s++) begin
        if (!loaded[s]) begin
          load_slot(s[IDX_BITS-1:0], rand_coord(), rand_coord(), rand_coord());
        end
      end

      // One phase runs the sender flat out against a long sink hold-off.
      pressure_on = (ph == 3);
      if (pressure_on) begin
        hold_req = 1'b1;
      end

      n = $urandom_range(20, 60);
      repeat (n) begin
        kind = $urandom_range(0, 9);
        src  = (eff > 0) ? int'($urandom_range(0, eff - 1)) : 0;
        if (kind < 3) begin
          // reload, half the time inside the searched range
          if (eff > 0 && $urandom_range(0, 1) == 1) begin
            slot = src[IDX_BITS-1:0];
          end else begin
            slot = IDX_BITS'($urandom_range(0, SLOTS - 1));
          end
          src = $urandom_range(0, SLOTS - 1);
          if (kind == 0 && loaded[src]) begin
            // copy of another centre: equal distances, tie handling
            x = sb.centre_x[src];
            y = sb.centre_y[src];
            z = sb.centre_z[src];
          end else begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
          end
          load_slot(slot, x, y, z);
        end else begin
          if (eff > 0 && kind == 3) begin
            x = sb.centre_x[src];
            y = sb.centre_y[src];
            z = sb.centre_z[src];
          end else if (eff > 0 && kind < 6) begin
            x = near_coord(sb.centre_x[src]);
            y = near_coord(sb.centre_y[src]);
            z = near_coord(sb.centre_z[src]);
          end else begin
            x = rand_coord();
            y = rand_coord();
            z = rand_coord();
          end
          send_item(OP_QUERY, IDX_BITS'($urandom_range(0, SLOTS - 1)), x, y, z);
        end
      end
      pressure_on = 1'b0;
    end

    settle();
    if (sb.awaited_q.size() != 0) begin
      $error("%0d query results never arrived", sb.awaited_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("tb_top failed");
    $finish;
  end

endmodule
